>>> rtl/lbde_pkg.sv
// ----------------------------------------------------------------------------
// lbde_pkg: shared definitions for the limited broadcast directory entry
// Request codes, field widths and the interface types of the shared counter.
// ----------------------------------------------------------------------------
package lbde_pkg;

	localparam int NumCoresDef = 64;
	localparam int CoreW       = 6;
	localparam int LimitW      = 7;
	localparam int TotalW      = 7;
	localparam int CntW        = 8;
	localparam int InDataW     = 8;
	localparam int OutDataW    = 24;

	localparam logic [LimitW-1:0] LimitRst = 7'd4;

	localparam logic [1:0] ReqAdd    = 2'd0;
	localparam logic [1:0] ReqRemove = 2'd1;
	localparam logic [1:0] ReqOwner  = 2'd2;
	localparam logic [1:0] ReqList   = 2'd3;

	typedef struct packed {
		logic            dec;
		logic [CntW-1:0] operand;
	} unit_ctl_t;

	typedef struct packed {
		logic [CntW-1:0] result;
		logic            operand_zero;
		logic            result_zero;
	} unit_rsp_t;

endpackage

>>> rtl/lbde_count_unit.sv
// ----------------------------------------------------------------------------
// lbde_count_unit: shared increment/decrement unit
// Adds or subtracts one and flags zero operands and zero results.
// ----------------------------------------------------------------------------
module lbde_count_unit (
	input  lbde_pkg::unit_ctl_t ctl,
	output lbde_pkg::unit_rsp_t rsp
);

	localparam int CntW = lbde_pkg::CntW;

	logic [CntW-1:0] sum;

	always_comb begin
		if (ctl.dec) begin
			sum = ctl.operand - CntW'(1);
		end else begin
			sum = ctl.operand + CntW'(1);
		end
		rsp.result       = sum;
		rsp.operand_zero = (ctl.operand == '0);
		rsp.result_zero  = (sum == '0);
	end

endmodule

>>> rtl/limited_broadcast_directory_entry.sv
// ----------------------------------------------------------------------------
// limited_broadcast_directory_entry: one coherence directory entry
// Presence bits with a broadcast fallback, a sharer count and an owner.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ group: s_tuser carries the request kind and
// s_tdata the core number and the owner-clear flag. Every result word leaves
// on the m_ group; m_tlast marks the final word caused by a request and
// m_tuser says whether m_tdata carries a listed sharer.
// Add, remove and set-owner requests give one result word: the execute
// state updates the entry through the shared increment/decrement unit and
// the response state loads the output register. A list request scans the
// presence bits after the update, one bit per cycle while the output register
// is free, and gives one word per set bit; in broadcast mode or with no
// sharers it gives a single status word instead.
// Only one request is in flight; s_tready returns the cycle after the last
// result word has been taken. A stalled receiver simply holds the scan.
// The hardware sharer limit is written through cfg_wr_en and cfg_wr_data;
// the user must write it only while the entry is idle, as the block itself
// does not enforce this. Reset clears the entry, drops any pending word and
// sets the limit to four.
// ----------------------------------------------------------------------------
module limited_broadcast_directory_entry #(
	parameter int NUM_CORES = lbde_pkg::NumCoresDef
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [lbde_pkg::LimitW-1:0]     cfg_wr_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [5:0] core_id, [6] owner_clear, [7] zero
	input  logic [lbde_pkg::InDataW-1:0]    s_tdata,
	// [1:0] req_type
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [5:0] sharer_id, [6] broadcast_mode, [13:7] sharer_total,
	// [19:14] owner_core, [20] owner_valid, [21] is_sharer, [22] error, [23] zero
	output logic [lbde_pkg::OutDataW-1:0]   m_tdata,
	// [0] sharer_valid
	output logic                            m_tuser,
	output logic                            m_tlast
);

	localparam int CoreW  = lbde_pkg::CoreW;
	localparam int TotalW = lbde_pkg::TotalW;
	localparam int LimitW = lbde_pkg::LimitW;
	localparam int CntW   = lbde_pkg::CntW;
	localparam int IdxW   = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

	localparam logic [TotalW-1:0] CoreLim = TotalW'(NUM_CORES);
	localparam logic [CntW-1:0]   CoreCnt = CntW'(NUM_CORES);

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StExec = 2'd1;
	localparam logic [1:0] StResp = 2'd2;
	localparam logic [1:0] StScan = 2'd3;

	logic [1:0]           st_q;
	logic [LimitW-1:0]    limit_q;
	logic [NUM_CORES-1:0] bits_q;
	logic [TotalW-1:0]    pop_q;
	logic                 bcast_q;
	logic [TotalW-1:0]    bcnt_q;
	logic [CoreW-1:0]     owner_q;
	logic                 own_v_q;
	logic [IdxW-1:0]      idx_q;
	logic [TotalW-1:0]    rem_q;
	logic                 m_tvalid_q;

	logic [1:0]           req_q;
	logic [CoreW-1:0]     core_q;
	logic                 clr_q;
	logic                 err_q;
	logic [lbde_pkg::OutDataW-1:0] m_tdata_q;
	logic                 m_tuser_q;
	logic                 m_tlast_q;

	lbde_pkg::unit_ctl_t  u_ctl;
	lbde_pkg::unit_rsp_t  u_rsp;

	logic                 in_range;
	logic [IdxW-1:0]      core_idx;
	logic                 core_bit;
	logic                 is_shr;
	logic [TotalW-1:0]    total;
	logic                 pop_at_limit;
	logic                 scan_bit;
	logic                 out_free;
	logic                 m_load;
	logic                 list_scan;
	logic [TotalW-1:0]    res7;
	logic [TotalW-1:0]    sat7;
	logic                 err_c;
	logic [CoreW-1:0]     sid_c;

	lbde_count_unit u_count (
		.ctl (u_ctl),
		.rsp (u_rsp)
	);

	assign in_range     = ({1'b0, core_q} < CoreLim);
	assign core_idx     = core_q[IdxW-1:0];
	assign core_bit     = in_range && bits_q[core_idx];
	assign is_shr       = bcast_q || core_bit;
	assign total        = bcast_q ? bcnt_q : pop_q;
	assign pop_at_limit = (pop_q == limit_q);
	assign scan_bit     = bits_q[idx_q];
	assign out_free     = !m_tvalid_q || m_tready;
	assign m_load       = out_free && ((st_q == StResp) || ((st_q == StScan) && scan_bit));
	assign list_scan    = (req_q == lbde_pkg::ReqList) && !bcast_q && (pop_q != '0);
	assign res7         = u_rsp.result[TotalW-1:0];
	assign sat7         = (u_rsp.result > CoreCnt) ? CoreLim : res7;
	assign sid_c        = CoreW'(idx_q);

	assign s_tready = (st_q == StIdle) && !m_tvalid_q;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// The shared unit counts the scan down while listing, and otherwise
	// works on whichever count the pending request changes.
	always_comb begin
		if (st_q == StScan) begin
			u_ctl.dec     = 1'b1;
			u_ctl.operand = {1'b0, rem_q};
		end else if (req_q == lbde_pkg::ReqRemove) begin
			u_ctl.dec     = 1'b1;
			u_ctl.operand = {1'b0, total};
		end else begin
			u_ctl.dec     = 1'b0;
			if (bcast_q) begin
				u_ctl.operand = {1'b0, bcnt_q};
			end else if (pop_at_limit) begin
				u_ctl.operand = {1'b0, limit_q};
			end else begin
				u_ctl.operand = {1'b0, pop_q};
			end
		end
	end

	always_comb begin
		case (req_q)
			lbde_pkg::ReqAdd: begin
				err_c = !in_range || (!bcast_q && core_bit);
			end
			lbde_pkg::ReqRemove: begin
				err_c = !in_range || (bcast_q ? (bcnt_q == '0) : !core_bit);
			end
			lbde_pkg::ReqOwner: begin
				err_c = !clr_q && (!in_range || (bcast_q ? (bcnt_q == '0) : !core_bit));
			end
			default: begin
				err_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= StIdle;
			limit_q    <= lbde_pkg::LimitRst;
			bits_q     <= '0;
			pop_q      <= '0;
			bcast_q    <= 1'b0;
			bcnt_q     <= '0;
			owner_q    <= '0;
			own_v_q    <= 1'b0;
			idx_q      <= '0;
			rem_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (m_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (st_q)
				StIdle: begin
					if (s_tvalid && s_tready) begin
						st_q <= StExec;
					end
				end
				StExec: begin
					case (req_q)
						lbde_pkg::ReqAdd: begin
							if (in_range && bcast_q) begin
								bcnt_q <= sat7;
							end else if (in_range && !core_bit) begin
								if (pop_at_limit) begin
									// Limit reached: fall back to counting only.
									bcast_q <= 1'b1;
									bcnt_q  <= sat7;
									bits_q  <= '0;
									pop_q   <= '0;
								end else begin
									bits_q[core_idx] <= 1'b1;
									pop_q            <= res7;
								end
							end
						end
						lbde_pkg::ReqRemove: begin
							if (in_range) begin
								if (bcast_q) begin
									if (!u_rsp.operand_zero) begin
										bcnt_q <= res7;
										if (u_rsp.result_zero) begin
											bcast_q <= 1'b0;
										end
									end
								end else if (core_bit) begin
									bits_q[core_idx] <= 1'b0;
									pop_q            <= res7;
								end
							end
						end
						lbde_pkg::ReqOwner: begin
							if (clr_q) begin
								owner_q <= '0;
								own_v_q <= 1'b0;
							end else if (in_range) begin
								owner_q <= core_q;
								own_v_q <= 1'b1;
							end
						end
						default: begin
							idx_q <= '0;
							rem_q <= pop_q;
						end
					endcase
					st_q <= list_scan ? StScan : StResp;
				end
				StResp: begin
					if (out_free) begin
						st_q <= StIdle;
					end
				end
				StScan: begin
					if (out_free) begin
						idx_q <= idx_q + IdxW'(1);
						if (scan_bit) begin
							rem_q <= res7;
							if (rem_q == TotalW'(1)) begin
								st_q <= StIdle;
							end
						end
					end
				end
				default: begin
					st_q <= StIdle;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q  <= s_tuser;
			core_q <= s_tdata[CoreW-1:0];
			clr_q  <= s_tdata[CoreW];
		end
		if (st_q == StExec) begin
			err_q <= err_c;
		end
		if ((st_q == StResp) && out_free) begin
			m_tdata_q <= {1'b0, err_q, is_shr, own_v_q, owner_q, total, bcast_q, {CoreW{1'b0}}};
			m_tuser_q <= 1'b0;
			m_tlast_q <= 1'b1;
		end else if ((st_q == StScan) && out_free && scan_bit) begin
			m_tdata_q <= {1'b0, 1'b0, is_shr, own_v_q, owner_q, total, bcast_q, sid_c};
			m_tuser_q <= 1'b1;
			m_tlast_q <= (rem_q == TotalW'(1));
		end
	end

`ifndef SYNTHESIS
	a_bcast_clean: assert property (@(posedge clk) disable iff (!arst_n)
		bcast_q |-> (bits_q == '0) && (pop_q == '0))
		else $error("presence bits left set in broadcast mode");

	a_bcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bcast_q |-> (bcnt_q != '0) && (bcnt_q <= CoreLim))
		else $error("broadcast count out of range");

	a_bcnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!bcast_q |-> (bcnt_q == '0))
		else $error("broadcast count left over outside broadcast mode");

	a_pop_track: assert property (@(posedge clk) disable iff (!arst_n)
		pop_q == TotalW'($countones(bits_q)))
		else $error("sharer count disagrees with presence bits");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tlast_q) |-> (st_q == StIdle))
		else $error("final word shown while the request is still in progress");
`endif

endmodule
